FILE: rtl/core/pcpd_pkg.sv
// ----------------------------------------------------------------------------
// pcpd_pkg
// Shared types and constants of the column-post picture decoder.
// ----------------------------------------------------------------------------
package pcpd_pkg;

  // Palette geometry
  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);

  // Input item kinds (travel on tuser)
  localparam logic [1:0] OP_PALETTE = 2'd0;
  localparam logic [1:0] OP_BEGIN   = 2'd1;
  localparam logic [1:0] OP_COLUMN  = 2'd2;

  // Top-delta value that closes a column
  localparam logic [7:0] END_OF_COLUMN = 8'hFF;

  typedef logic [23:0] rgb_t;

  // Pixel issue from the parser to the output stage
  typedef struct packed {
    logic       pixel;
    logic [7:0] row;
    logic [7:0] column;
  } pix_t;

endpackage

FILE: rtl/core/patch_column_post_decoder.sv
// ----------------------------------------------------------------------------
// patch_column_post_decoder
// Column-post picture decoder: palette loads, post parsing, RGB pixel output.
// ----------------------------------------------------------------------------
// Timing: a pixel result is registered and valid in the cycle after its index byte's transaction.
// Throughput: one input transaction per cycle while the output is not stalled; set by the
//   single palette read port, which serves one index per cycle while writes use the other port.
// Reset: clears parse phase, row, column, pixel count and the output valid flag.
//   The palette memory is not cleared; entries are undefined until loaded.
module patch_column_post_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // data_byte[7:0], palette_slot[15:8], palette_rgb[39:16]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // pixel_row, pixel_column, red, green, blue (low first)
);
  import pcpd_pkg::*;

  logic       accept;
  logic [7:0] data_byte;
  logic [7:0] palette_slot;
  rgb_t       palette_rgb;
  pix_t       pix;
  rgb_t       color;
  logic       out_valid;
  logic [7:0] out_row;
  logic [7:0] out_column;

  assign data_byte    = s_axis_tdata[7:0];
  assign palette_slot = s_axis_tdata[15:8];
  assign palette_rgb  = s_axis_tdata[39:16];

  // Take a new transaction whenever the output stage is free or draining
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  pcpd_post_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .opcode    (s_axis_tuser),
    .data_byte (data_byte),
    .pix       (pix)
  );

  pcpd_palette_ram u_palette (
    .clk     (clk),
    .wr_en   (accept && (s_axis_tuser == OP_PALETTE)),
    .wr_addr (palette_slot[PAL_AW-1:0]),
    .wr_data (palette_rgb),
    .rd_en   (pix.pixel),
    .rd_addr (data_byte[PAL_AW-1:0]),
    .rd_data (color)
  );

  // Output stage: row/column beside the registered palette read
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid <= pix.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (pix.pixel) begin
      out_row    <= pix.row;
      out_column <= pix.column;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {color[7:0], color[15:8], color[23:16], out_column, out_row};

endmodule

FILE: rtl/core/pcpd_palette_ram.sv
// ----------------------------------------------------------------------------
// pcpd_palette_ram
// Palette color store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pcpd_palette_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [pcpd_pkg::PAL_AW-1:0] wr_addr,
  input  pcpd_pkg::rgb_t            wr_data,
  input  logic                      rd_en,
  input  logic [pcpd_pkg::PAL_AW-1:0] rd_addr,
  output pcpd_pkg::rgb_t            rd_data
);
  import pcpd_pkg::*;

  rgb_t mem [PAL_ENTRIES];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/pcpd_post_parser.sv
// ----------------------------------------------------------------------------
// pcpd_post_parser
// Post parser: tracks phase, row, column and remaining pixel count per byte.
// ----------------------------------------------------------------------------
module pcpd_post_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [1:0]     opcode,
  input  logic [7:0]     data_byte,
  output pcpd_pkg::pix_t pix
);
  import pcpd_pkg::*;

  localparam logic [2:0] PH_TOP  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_PAD1 = 3'd2;
  localparam logic [2:0] PH_PIX  = 3'd3;
  localparam logic [2:0] PH_PAD2 = 3'd4;

  logic [2:0] phase, phase_next;
  logic [7:0] row, row_next;
  logic [7:0] column, column_next;
  logic [7:0] left, left_next;
  logic [7:0] left_dec;

  assign left_dec = left - 8'd1;

  // Next-state logic for one accepted transaction
  always_comb begin
    phase_next  = phase;
    row_next    = row;
    column_next = column;
    left_next   = left;
    pix.pixel   = 1'b0;
    pix.row     = row;
    pix.column  = column;
    if (accept) begin
      case (opcode)
        OP_BEGIN: begin
          phase_next  = PH_TOP;
          row_next    = '0;
          column_next = '0;
          left_next   = '0;
        end
        OP_COLUMN: begin
          case (phase)
            PH_TOP: begin
              if (data_byte == END_OF_COLUMN) begin
                column_next = column + 8'd1;
              end else begin
                row_next   = data_byte;
                phase_next = PH_LEN;
              end
            end
            PH_LEN: begin
              left_next  = data_byte;
              phase_next = PH_PAD1;
            end
            PH_PAD1: begin
              phase_next = (left != '0) ? PH_PIX : PH_PAD2;
            end
            PH_PIX: begin
              pix.pixel = 1'b1;
              row_next  = row + 8'd1;
              left_next = left_dec;
              if (left_dec == '0) begin
                phase_next = PH_PAD2;
              end
            end
            default: begin
              phase_next = PH_TOP;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_TOP;
      row    <= '0;
      column <= '0;
      left   <= '0;
    end else begin
      phase  <= phase_next;
      row    <= row_next;
      column <= column_next;
      left   <= left_next;
    end
  end

endmodule

FILE: rtl/core/pcpd_checker.sv
// ----------------------------------------------------------------------------
// pcpd_checker
// Port-level checks of the decoder's stream behavior.
// ----------------------------------------------------------------------------
module pcpd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata
);
  import pcpd_pkg::*;

  // A stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pcpd: stalled result changed");

  // Empty output stage never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("pcpd: input blocked while output empty");

  // Reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("pcpd: result valid after reset");

  // Only column bytes can produce a result
  a_noncol: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_COLUMN) |=> !m_axis_tvalid)
    else $error("pcpd: result from a non-column transaction");

  // A result needs a transaction in the cycle before
  a_cause: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid ##1 m_axis_tvalid |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("pcpd: result without a cause");

endmodule

bind patch_column_post_decoder pcpd_checker u_pcpd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the column-post picture decoder. A behavioral decoder tracks post
// parsing and the palette as each input transaction goes in, and queues the
// pixel it should produce. Every output transaction is compared field by
// field against the oldest queued pixel. Directed tests cover the palette
// extremes, post framing, zero-length posts, row and column wrap, an unused
// opcode and long posts under output back-pressure. These are followed by
// random columns with noise and by a tail with no idling on either side.
// ----------------------------------------------------------------------------
module testbench;
  import pcpd_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         LONG_HOLD      = 400;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         DRAIN_TAIL     = 10;
  localparam int         MAX_REPORTS    = 10;

  // Post parser phases
  typedef enum logic [2:0] {
    EXPECT_TOP,
    EXPECT_LENGTH,
    EXPECT_PAD_HEAD,
    EXPECT_INDEX,
    EXPECT_PAD_TAIL
  } post_phase_t;

  // Output tdata layout, row in the lowest byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] pixel_column;
    logic [7:0] pixel_row;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // data_byte[7:0], palette_slot[15:8], palette_rgb[39:16]
  logic [1:0]  s_axis_tuser = '0;   // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // pixel_row, pixel_column, red, green, blue

  // Decoder state as predicted
  post_phase_t          phase = EXPECT_TOP;
  logic [7:0]           row_pos = '0;
  logic [7:0]           col_pos = '0;
  logic [7:0]           pixels_left = '0;
  rgb_t                 palette_mem [PAL_ENTRIES];
  logic [PAL_ENTRIES-1:0] slot_loaded = '0;
  pixel_t               expected_pixels [$];

  int  items_sent    = 0;
  int  error_count   = 0;
  int  idle_cycles   = 0;
  int  gap_odds      = 0;   // 0 disables sender gaps, else 1 in N
  int  stall_odds    = 0;   // 0 disables receiver stalls, else 1 in N
  bit  hold_req      = 1'b0;

  patch_column_post_decoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted decoder: update state for one accepted transaction
  task automatic decode_item(input logic [1:0] op, input logic [7:0] data,
                             input logic [7:0] slot, input rgb_t rgb);
    pixel_t px;
    rgb_t   color;
    case (op)
      OP_PALETTE: begin
        if (slot < PAL_ENTRIES) begin
          palette_mem[slot] = rgb;
          slot_loaded[slot] = 1'b1;
        end
      end
      OP_BEGIN: begin
        phase       = EXPECT_TOP;
        row_pos     = '0;
        col_pos     = '0;
        pixels_left = '0;
      end
      OP_COLUMN: begin
        case (phase)
          EXPECT_TOP: begin
            if (data == END_OF_COLUMN) begin
              col_pos = col_pos + 8'd1;
            end else begin
              row_pos = data;
              phase   = EXPECT_LENGTH;
            end
          end
          EXPECT_LENGTH: begin
            pixels_left = data;
            phase       = EXPECT_PAD_HEAD;
          end
          EXPECT_PAD_HEAD: begin
            phase = (pixels_left != 0) ? EXPECT_INDEX : EXPECT_PAD_TAIL;
          end
          EXPECT_INDEX: begin
            color = (data < PAL_ENTRIES) ? palette_mem[data] : '0;
            px.pixel_row    = row_pos;
            px.pixel_column = col_pos;
            px.red          = color[23:16];
            px.green        = color[15:8];
            px.blue         = color[7:0];
            expected_pixels.push_back(px);
            row_pos     = row_pos + 8'd1;
            pixels_left = pixels_left - 8'd1;
            if (pixels_left == 0) phase = EXPECT_PAD_TAIL;
          end
          default: begin
            phase = EXPECT_TOP;
          end
        endcase
      end
      default: ;
    endcase
  endtask

  // Random palette index among the entries already loaded
  function automatic logic [7:0] pick_index();
    logic [7:0] idx;
    idx = 8'($urandom_range(0, PAL_ENTRIES - 1));
    while (!slot_loaded[idx]) idx = idx + 8'd1;
    return idx;
  endfunction

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'd0;
    if (r < 80) return 8'($urandom_range(1, 6));
    if (r < 97) return 8'($urandom_range(7, 40));
    return 8'($urandom_range(41, 255));
  endfunction

  // Offer one transaction and wait until it is taken
  task automatic send_item(input logic [1:0] op, input logic [7:0] data,
                           input logic [7:0] slot, input rgb_t rgb);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rgb, slot, data};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    decode_item(op, data, slot, rgb);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Column byte; a byte landing on an index is kept to loaded entries
  task automatic send_column(input logic [7:0] data);
    logic [7:0] b;
    b = data;
    if (phase == EXPECT_INDEX && !slot_loaded[b]) b = pick_index();
    send_item(OP_COLUMN, b, 8'($urandom), 24'($urandom));
  endtask

  task automatic send_palette(input logic [7:0] slot, input rgb_t rgb);
    send_item(OP_PALETTE, 8'($urandom), slot, rgb);
  endtask

  task automatic send_begin();
    send_item(OP_BEGIN, 8'($urandom), 8'($urandom), 24'($urandom));
  endtask

  task automatic send_unused();
    send_item(OP_UNUSED, 8'($urandom), 8'($urandom), 24'($urandom));
  endtask

  // One post; in noisy mode palette loads, unused opcodes and patch restarts
  // may land in the middle of it
  task automatic send_post(input logic [7:0] top, input logic [7:0] len,
                           input bit noisy);
    int r;
    send_column(top);
    send_column(len);
    send_column(8'($urandom));
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        r = $urandom_range(0, 59);
        if (r < 2) send_palette(8'($urandom), 24'($urandom));
        else if (r == 2) send_unused();
        else if (r == 3 && $urandom_range(0, 3) == 0) send_begin();
      end
      send_column(pick_index());
    end
    send_column(8'($urandom));
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_palette_extremes();
    send_palette(8'h00, 24'h000000);
    send_palette(8'hFF, 24'hFFFFFF);
    send_palette(8'h55, 24'hA5C3F0);
    send_palette(8'hAA, 24'h5A3C0F);
    // Unused opcode with every data bit set
    send_item(OP_UNUSED, 8'hFF, 8'hFF, 24'hFFFFFF);
  endtask

  task automatic test_post_framing();
    send_begin();
    send_column(8'd0);
    send_column(8'd3);
    send_column(8'h00);
    send_column(8'h00);
    send_column(8'hFF);
    send_column(8'hAA);
    send_column(8'hFF);
    // Zero-length post
    send_post(8'd7, 8'd0, 1'b0);
    send_column(END_OF_COLUMN);
    // Row wraps past 255; palette load and unused opcode mid-post
    send_column(8'd250);
    send_column(8'd10);
    send_column(8'h5C);
    for (int i = 0; i < 10; i++) begin
      if (i == 3) send_palette(8'h10, 24'h123456);
      if (i == 5) send_unused();
      send_column((i == 4) ? 8'h10 : pick_index());
    end
    send_column(8'h00);
    send_column(END_OF_COLUMN);
  endtask

  task automatic test_column_wrap();
    gap_odds   = 0;
    stall_odds = 0;
    send_begin();
    repeat (257) send_column(END_OF_COLUMN);
    send_post(8'd3, 8'd2, 1'b0);
    send_column(END_OF_COLUMN);
    send_begin();
    send_post(8'd1, 8'd1, 1'b0);
  endtask

  task automatic test_output_backpressure();
    gap_odds   = 12;
    stall_odds = 8;
    hold_req   = 1'b1;
    send_begin();
    send_post(8'd0, 8'd255, 1'b0);
    send_column(END_OF_COLUMN);
    pause_until_drained();
  endtask

  task automatic test_random_columns(input int target, input bit vary_idle);
    int r;
    int stop;
    stop = items_sent + target;
    while (items_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        repeat ($urandom_range(0, 3)) send_post(8'($urandom_range(0, 254)), pick_length(), 1'b1);
        send_column(END_OF_COLUMN);
      end else if (r < 78) begin
        send_begin();
      end else if (r < 88) begin
        send_palette(8'($urandom), 24'($urandom));
      end else if (r < 95) begin
        repeat ($urandom_range(1, 5)) send_column(8'($urandom));
      end else begin
        send_unused();
      end
      // Vary idling density between stretches
      if (vary_idle && $urandom_range(0, 19) == 0) begin
        gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
        stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
      end
    end
  endtask

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    got = m_axis_tdata;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected pixel: row %0d col %0d rgb %02h%02h%02h",
                   got.pixel_row, got.pixel_column, got.red, got.green, got.blue);
      end else begin
        want = expected_pixels.pop_front();
        if (got.pixel_row !== want.pixel_row || got.pixel_column !== want.pixel_column ||
            got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch: want row %0d col %0d rgb %06h, got row %0d col %0d rgb %06h",
                     want.pixel_row, want.pixel_column, {want.red, want.green, want.blue},
                     got.pixel_row, got.pixel_column, {got.red, got.green, got.blue});
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_odds   = 4;
    stall_odds = 4;
    test_palette_extremes();
    test_post_framing();
    test_column_wrap();
    test_output_backpressure();
    gap_odds   = 5;
    stall_odds = 5;
    test_random_columns(600, 1'b1);
    gap_odds   = 0;
    stall_odds = 0;
    test_random_columns(100, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pcpd_pkg.sv
rtl/core/pcpd_palette_ram.sv
rtl/core/pcpd_post_parser.sv
rtl/core/patch_column_post_decoder.sv
rtl/core/pcpd_checker.sv
tb/testbench.sv
